[src/i2cm_pkg.sv]
// Shared types, codes and reset constants for the I2C master bit engine.
package i2cm_pkg;

    localparam int unsigned REG_W = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [REG_W-1:0] EDGE_HOLD_RST   = 8'd5;
    localparam logic [REG_W-1:0] HALF_BIT_RST    = 8'd2;
    localparam logic [REG_W-1:0] SETTLE_RST      = 8'd1;
    localparam logic [REG_W-1:0] ACK_TIMEOUT_RST = 8'd250;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_HOLD   = 2'd0,
        CFG_HALF_BIT    = 2'd1,
        CFG_SETTLE      = 2'd2,
        CFG_ACK_TIMEOUT = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        REQ_NONE     = 3'd0,
        REQ_START    = 3'd1,
        REQ_STOP     = 3'd2,
        REQ_WRITE    = 3'd3,
        REQ_WAIT_ACK = 3'd4,
        REQ_READ     = 3'd5
    } req_code_t;

    typedef enum logic [15:0] {
        PH_IDLE    = 16'h0001,
        PH_ST_A    = 16'h0002,
        PH_ST_B    = 16'h0004,
        PH_SP_A    = 16'h0008,
        PH_SP_B    = 16'h0010,
        PH_WR_LOW  = 16'h0020,
        PH_WR_HIGH = 16'h0040,
        PH_WA_SET  = 16'h0080,
        PH_WA_HIGH = 16'h0100,
        PH_WA_POLL = 16'h0200,
        PH_RD_LOW  = 16'h0400,
        PH_RD_HIGH = 16'h0800,
        PH_AK_LOW  = 16'h1000,
        PH_AK_HIGH = 16'h2000,
        PH_FS_A    = 16'h4000,
        PH_FS_B    = 16'h8000
    } phase_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       give_ack;
        logic       sda_in;
    } i2cm_in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } i2cm_out_t;

    typedef struct packed {
        logic [REG_W-1:0] edge_hold_ticks;
        logic [REG_W-1:0] half_bit_ticks;
        logic [REG_W-1:0] settle_ticks;
        logic [REG_W-1:0] ack_timeout_ticks;
    } i2cm_cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic [7:0] wait_count;
        logic [7:0] poll_count;
        logic       ack_choice;
        logic       scl;
        logic       sda;
        logic       drv;
    } i2cm_state_t;

endpackage

[src/i2cm_cfg.sv]
// Configuration register file for the tick-count settings.
module i2cm_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [i2cm_pkg::REG_W-1:0]      cfg_wr_data,
    output i2cm_pkg::i2cm_cfg_t             cfg
);
    import i2cm_pkg::*;

    i2cm_cfg_t cfg_reg;
    i2cm_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_wr_index))
                CFG_EDGE_HOLD:   cfg_next.edge_hold_ticks   = cfg_wr_data;
                CFG_HALF_BIT:    cfg_next.half_bit_ticks    = cfg_wr_data;
                CFG_SETTLE:      cfg_next.settle_ticks      = cfg_wr_data;
                CFG_ACK_TIMEOUT: cfg_next.ack_timeout_ticks = cfg_wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.edge_hold_ticks   <= EDGE_HOLD_RST;
            cfg_reg.half_bit_ticks    <= HALF_BIT_RST;
            cfg_reg.settle_ticks      <= SETTLE_RST;
            cfg_reg.ack_timeout_ticks <= ACK_TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/i2cm_step.sv]
// Next-state and result logic for one tick of the bit engine.
module i2cm_step (
    input  i2cm_pkg::i2cm_state_t cur,
    input  i2cm_pkg::i2cm_in_t    in_item,
    input  i2cm_pkg::i2cm_cfg_t   cfg,
    output i2cm_pkg::i2cm_state_t nxt,
    output i2cm_pkg::i2cm_out_t   res
);
    import i2cm_pkg::*;

    logic [7:0] hold_sel;
    logic [7:0] hold_lim;
    logic [7:0] wait_inc;
    logic       hold_done;
    logic [7:0] hold_wait;
    logic [3:0] bit_inc;
    logic [7:0] shift_up;
    logic       done;
    logic       fail;
    logic [7:0] rx;

    // Each timed phase waits on exactly one tick count; pick it first.
    always_comb begin
        case (cur.phase)
            PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_FS_A, PH_FS_B:
                hold_sel = cfg.edge_hold_ticks;
            PH_WR_LOW, PH_WR_HIGH, PH_RD_LOW, PH_AK_LOW:
                hold_sel = cfg.half_bit_ticks;
            PH_WA_SET, PH_WA_HIGH, PH_RD_HIGH:
                hold_sel = cfg.settle_ticks;
            PH_AK_HIGH:
                hold_sel = cur.ack_choice ? cfg.edge_hold_ticks : cfg.half_bit_ticks;
            default:
                hold_sel = cfg.edge_hold_ticks;
        endcase
    end

    // A zero count behaves as one tick.
    assign hold_lim  = (hold_sel == 8'd0) ? 8'd1 : hold_sel;
    assign wait_inc  = cur.wait_count + 8'd1;
    assign hold_done = (wait_inc >= hold_lim);
    assign hold_wait = hold_done ? 8'd0 : wait_inc;
    assign bit_inc   = cur.bit_count + 4'd1;
    assign shift_up  = {cur.shift_byte[6:0], 1'b0};

    always_comb begin
        nxt  = cur;
        done = 1'b0;
        fail = 1'b0;
        rx   = 8'd0;
        case (cur.phase)
            PH_IDLE: begin
                nxt.wait_count = 8'd0;
                case (req_code_t'(in_item.req_type))
                    REQ_START: begin
                        nxt.drv   = 1'b1;
                        nxt.sda   = 1'b1;
                        nxt.scl   = 1'b1;
                        nxt.phase = PH_ST_A;
                    end
                    REQ_STOP: begin
                        nxt.drv   = 1'b1;
                        nxt.scl   = 1'b0;
                        nxt.sda   = 1'b0;
                        nxt.phase = PH_SP_A;
                    end
                    REQ_WRITE: begin
                        nxt.shift_byte = in_item.tx_byte;
                        nxt.bit_count  = 4'd0;
                        nxt.drv        = 1'b1;
                        nxt.scl        = 1'b0;
                        nxt.sda        = in_item.tx_byte[7];
                        nxt.phase      = PH_WR_LOW;
                    end
                    REQ_WAIT_ACK: begin
                        nxt.drv        = 1'b0;
                        nxt.sda        = 1'b1;
                        nxt.poll_count = 8'd0;
                        nxt.phase      = PH_WA_SET;
                    end
                    REQ_READ: begin
                        nxt.drv        = 1'b0;
                        nxt.sda        = 1'b1;
                        nxt.scl        = 1'b0;
                        nxt.shift_byte = 8'd0;
                        nxt.bit_count  = 4'd0;
                        nxt.ack_choice = in_item.give_ack;
                        nxt.phase      = PH_RD_LOW;
                    end
                    default: nxt.phase = PH_IDLE;
                endcase
            end
            PH_ST_A: begin
                nxt.wait_count = hold_wait;
                if (hold_done) begin
                    nxt.sda   = 1'b0;
                    nxt.phase = PH_ST_B;
                end
            end
            PH_ST_B: begin
                nxt.wait_count = hold_wait;
                if (hold_done) begin
                    nxt.scl   = 1'b0;
                    nxt.phase = PH_IDLE;
                    done      = 1'b1;
                end
            end
            PH_SP_A, PH_FS_A: begin
                nxt.wait_count = hold_wait;
                if (hold_done) begin
                    nxt.scl   = 1'b1;
                    nxt.sda   = 1'b1;
                    nxt.phase = (cur.phase == PH_SP_A) ? PH_SP_B : PH_FS_B;
                end
            end
            PH_SP_B, PH_FS_B: begin
                nxt.wait_count = hold_wait;
                if (hold_done) begin
                    fail      = (cur.phase == PH_FS_B);
                    nxt.phase = PH_IDLE;
                    done      = 1'b1;
                end
            end
            PH_WR_LOW: begin
                nxt.wait_count = hold_wait;
                if (hold_done) begin
                    nxt.scl   = 1'b1;
                    nxt.phase = PH_WR_HIGH;
                end
            end
            PH_WR_HIGH: begin
                nxt.wait_count = hold_wait;
                if (hold_done) begin
                    nxt.scl       = 1'b0;
                    nxt.bit_count = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        nxt.phase = PH_IDLE;
                        done      = 1'b1;
                    end else begin
                        nxt.shift_byte = shift_up;
                        nxt.sda        = shift_up[7];
                        nxt.phase      = PH_WR_LOW;
                    end
                end
            end
            PH_WA_SET: begin
                nxt.wait_count = hold_wait;
                if (hold_done) begin
                    nxt.scl   = 1'b1;
                    nxt.phase = PH_WA_HIGH;
                end
            end
            PH_WA_HIGH: begin
                nxt.wait_count = hold_wait;
                if (hold_done) begin
                    nxt.phase = PH_WA_POLL;
                end
            end
            PH_WA_POLL: begin
                if (!in_item.sda_in) begin
                    nxt.scl   = 1'b0;
                    nxt.phase = PH_IDLE;
                    done      = 1'b1;
                end else if (cur.poll_count >= cfg.ack_timeout_ticks) begin
                    // No ack in time: drive a stop condition, then flag failure.
                    nxt.drv        = 1'b1;
                    nxt.scl        = 1'b0;
                    nxt.sda        = 1'b0;
                    nxt.wait_count = 8'd0;
                    nxt.phase      = PH_FS_A;
                end else begin
                    nxt.poll_count = cur.poll_count + 8'd1;
                end
            end
            PH_RD_LOW: begin
                nxt.wait_count = hold_wait;
                if (hold_done) begin
                    nxt.scl   = 1'b1;
                    nxt.phase = PH_RD_HIGH;
                end
            end
            PH_RD_HIGH: begin
                nxt.wait_count = hold_wait;
                if (hold_done) begin
                    nxt.shift_byte = {cur.shift_byte[6:0], in_item.sda_in};
                    nxt.bit_count  = bit_inc;
                    nxt.scl        = 1'b0;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        nxt.drv   = 1'b1;
                        nxt.sda   = ~cur.ack_choice;
                        nxt.phase = PH_AK_LOW;
                    end else begin
                        nxt.phase = PH_RD_LOW;
                    end
                end
            end
            PH_AK_LOW: begin
                nxt.wait_count = hold_wait;
                if (hold_done) begin
                    nxt.scl   = 1'b1;
                    nxt.phase = PH_AK_HIGH;
                end
            end
            PH_AK_HIGH: begin
                nxt.wait_count = hold_wait;
                if (hold_done) begin
                    nxt.scl   = 1'b0;
                    nxt.phase = PH_IDLE;
                    done      = 1'b1;
                    rx        = cur.shift_byte;
                end
            end
            default: begin
                nxt.phase      = PH_IDLE;
                nxt.wait_count = 8'd0;
            end
        endcase
    end

    always_comb begin
        res.scl_level  = nxt.scl;
        res.sda_level  = nxt.sda;
        res.sda_drive  = nxt.drv;
        res.busy_res   = (nxt.phase != PH_IDLE);
        res.done_res   = done;
        res.rx_byte    = rx;
        res.ack_failed = fail;
    end

endmodule

[src/i2cm_out_reg.sv]
// Result register that holds one tick's outputs until the consumer takes them.
module i2cm_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  i2cm_pkg::i2cm_out_t load_data,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output i2cm_pkg::i2cm_out_t m_data
);
    import i2cm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    i2cm_out_t data_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

[src/i2c_master_bit_engine.sv]
// Top level of the I2C master bit engine: tick state, settings and result register.
//
//  Channel   Ports                         Carries
//  --------  ----------------------------  ----------------------------------------
//  input     s_valid, s_ready, s_data      one tick: request, tx byte, ack choice, SDA
//  result    m_valid, m_ready, m_data      line levels, busy, done, rx byte, ack fail
//  config    cfg_wr_en, cfg_wr_index, ...  tick-count settings, write only
//
// One tick transfer is accepted every clock while the result register is empty or
// being emptied; its result is presented on the next clock. The throughput of one
// tick per cycle is set by the single engine state register, updated once per
// transfer. Reset (aresetn low, synchronous) returns the engine to idle with SCL
// and SDA high and driven, and loads the default tick counts. A stall on the
// result side holds the pending result and stops input transfers; it never drops
// or repeats a tick.
module i2c_master_bit_engine (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  i2cm_pkg::i2cm_in_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output i2cm_pkg::i2cm_out_t            m_data,
    input  logic                           cfg_wr_en,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [i2cm_pkg::REG_W-1:0]     cfg_wr_data
);
    import i2cm_pkg::*;

    i2cm_cfg_t   cfg;
    i2cm_state_t state_reg;
    i2cm_state_t state_next;
    i2cm_out_t   step_res;
    logic        s_fire;

    // Settings must be rewritten only while the engine sits idle; the block itself does not enforce it.
    i2cm_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // One tick of work: all the phase logic is a single combinational pass.
    i2cm_step u_step (
        .cur     (state_reg),
        .in_item (s_data),
        .cfg     (cfg),
        .nxt     (state_next),
        .res     (step_res)
    );

    assign s_fire = s_valid && s_ready;

    // The engine state only moves when a tick transfer is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= PH_IDLE;
            state_reg.bit_count  <= 4'd0;
            state_reg.shift_byte <= 8'd0;
            state_reg.wait_count <= 8'd0;
            state_reg.poll_count <= 8'd0;
            state_reg.ack_choice <= 1'b0;
            state_reg.scl        <= 1'b1;
            state_reg.sda        <= 1'b1;
            state_reg.drv        <= 1'b1;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // The result register parts the two handshakes.
    i2cm_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_fire),
        .load_data (step_res),
        .can_load  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // A completed command never leaves the engine busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.done_res && m_data.busy_res))
        else $error("done and busy reported together");

    // An ack failure is only reported on a done tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.ack_failed) |-> m_data.done_res)
        else $error("ack failure without done");

    // Every accepted tick yields a result on the next clock.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("accepted tick produced no result");

    // The hold counter is always cleared while idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_IDLE) |-> (state_reg.wait_count == 8'd0))
        else $error("hold counter not clear in idle");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master bit engine, with a tick-level line predictor.
module tb;
    import i2cm_pkg::*;

    // Request codes the engine does not define; it must treat them as no request.
    localparam logic [2:0] REQ_RSVD_6 = 3'd6;
    localparam logic [2:0] REQ_RSVD_7 = 3'd7;

    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    // Ticks of random traffic per configuration setting.
    localparam int unsigned TICKS_PER_PHASE = 60;
    // A slave ack delay larger than any timeout, so the ack poll always fails.
    localparam int unsigned NO_ACK = 1000;
    // Cycles to keep watching the result channel after the last expected result.
    localparam int unsigned TAIL_CYCLES = 8;
    // Marks that the SDA level seen during reads is free to vary.
    localparam int SDA_FREE = -1;

    // Tracks the engine tick by tick and holds the line states it must report.
    class line_scoreboard;
        i2cm_cfg_t   cfg;
        i2cm_state_t st;
        i2cm_out_t   expected_q[$];
        int unsigned errors;

        function void reset_state();
            cfg = '{EDGE_HOLD_RST, HALF_BIT_RST, SETTLE_RST, ACK_TIMEOUT_RST};
            st = '0;
            st.phase = PH_IDLE;
            st.scl = 1'b1;
            st.sda = 1'b1;
            st.drv = 1'b1;
            expected_q.delete();
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [REG_W-1:0] v);
            case (idx)
                CFG_EDGE_HOLD:   cfg.edge_hold_ticks = v;
                CFG_HALF_BIT:    cfg.half_bit_ticks = v;
                CFG_SETTLE:      cfg.settle_ticks = v;
                CFG_ACK_TIMEOUT: cfg.ack_timeout_ticks = v;
                default: ;
            endcase
        endfunction

        // Counts one tick of a hold; a zero length behaves as a single tick.
        function bit hold_elapsed(logic [REG_W-1:0] n);
            logic [REG_W-1:0] lim;
            lim = (n == '0) ? 8'd1 : n;
            st.wait_count = st.wait_count + 8'd1;
            if (st.wait_count >= lim) begin
                st.wait_count = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Advances the engine by one accepted tick and queues the result it must show.
        function void note_tick(i2cm_in_t t);
            i2cm_out_t r;
            r = '0;
            case (st.phase)
                PH_IDLE: begin
                    st.wait_count = '0;
                    case (t.req_type)
                        REQ_START: begin
                            st.drv = 1'b1;
                            st.sda = 1'b1;
                            st.scl = 1'b1;
                            st.phase = PH_ST_A;
                        end
                        REQ_STOP: begin
                            st.drv = 1'b1;
                            st.scl = 1'b0;
                            st.sda = 1'b0;
                            st.phase = PH_SP_A;
                        end
                        REQ_WRITE: begin
                            st.shift_byte = t.tx_byte;
                            st.bit_count = '0;
                            st.drv = 1'b1;
                            st.scl = 1'b0;
                            st.sda = t.tx_byte[7];
                            st.phase = PH_WR_LOW;
                        end
                        REQ_WAIT_ACK: begin
                            st.drv = 1'b0;
                            st.sda = 1'b1;
                            st.poll_count = '0;
                            st.phase = PH_WA_SET;
                        end
                        REQ_READ: begin
                            st.drv = 1'b0;
                            st.sda = 1'b1;
                            st.scl = 1'b0;
                            st.shift_byte = '0;
                            st.bit_count = '0;
                            st.ack_choice = t.give_ack;
                            st.phase = PH_RD_LOW;
                        end
                        default: ;
                    endcase
                end
                PH_ST_A: begin
                    if (hold_elapsed(cfg.edge_hold_ticks)) begin
                        st.sda = 1'b0;
                        st.phase = PH_ST_B;
                    end
                end
                PH_ST_B: begin
                    if (hold_elapsed(cfg.edge_hold_ticks)) begin
                        st.scl = 1'b0;
                        st.phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
                PH_SP_A, PH_FS_A: begin
                    if (hold_elapsed(cfg.edge_hold_ticks)) begin
                        st.scl = 1'b1;
                        st.sda = 1'b1;
                        st.phase = (st.phase == PH_SP_A) ? PH_SP_B : PH_FS_B;
                    end
                end
                PH_SP_B, PH_FS_B: begin
                    if (hold_elapsed(cfg.edge_hold_ticks)) begin
                        r.ack_failed = (st.phase == PH_FS_B);
                        st.phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
                PH_WR_LOW: begin
                    if (hold_elapsed(cfg.half_bit_ticks)) begin
                        st.scl = 1'b1;
                        st.phase = PH_WR_HIGH;
                    end
                end
                PH_WR_HIGH: begin
                    if (hold_elapsed(cfg.half_bit_ticks)) begin
                        st.scl = 1'b0;
                        st.bit_count = st.bit_count + 4'd1;
                        if (st.bit_count >= BITS_PER_BYTE) begin
                            st.phase = PH_IDLE;
                            r.done_res = 1'b1;
                        end else begin
                            st.shift_byte = st.shift_byte << 1;
                            st.sda = st.shift_byte[7];
                            st.phase = PH_WR_LOW;
                        end
                    end
                end
                PH_WA_SET: begin
                    if (hold_elapsed(cfg.settle_ticks)) begin
                        st.scl = 1'b1;
                        st.phase = PH_WA_HIGH;
                    end
                end
                PH_WA_HIGH: begin
                    if (hold_elapsed(cfg.settle_ticks)) st.phase = PH_WA_POLL;
                end
                PH_WA_POLL: begin
                    if (!t.sda_in) begin
                        st.scl = 1'b0;
                        st.phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end else if (st.poll_count >= cfg.ack_timeout_ticks) begin
                        st.drv = 1'b1;
                        st.scl = 1'b0;
                        st.sda = 1'b0;
                        st.wait_count = '0;
                        st.phase = PH_FS_A;
                    end else begin
                        st.poll_count = st.poll_count + 8'd1;
                    end
                end
                PH_RD_LOW: begin
                    if (hold_elapsed(cfg.half_bit_ticks)) begin
                        st.scl = 1'b1;
                        st.phase = PH_RD_HIGH;
                    end
                end
                PH_RD_HIGH: begin
                    if (hold_elapsed(cfg.settle_ticks)) begin
                        st.shift_byte = {st.shift_byte[6:0], t.sda_in};
                        st.bit_count = st.bit_count + 4'd1;
                        st.scl = 1'b0;
                        if (st.bit_count >= BITS_PER_BYTE) begin
                            st.drv = 1'b1;
                            st.sda = !st.ack_choice;
                            st.phase = PH_AK_LOW;
                        end else begin
                            st.phase = PH_RD_LOW;
                        end
                    end
                end
                PH_AK_LOW: begin
                    if (hold_elapsed(cfg.half_bit_ticks)) begin
                        st.scl = 1'b1;
                        st.phase = PH_AK_HIGH;
                    end
                end
                PH_AK_HIGH: begin
                    if (hold_elapsed(st.ack_choice ? cfg.edge_hold_ticks
                                                   : cfg.half_bit_ticks)) begin
                        st.scl = 1'b0;
                        st.phase = PH_IDLE;
                        r.done_res = 1'b1;
                        r.rx_byte = st.shift_byte;
                    end
                end
                default: begin
                    st.phase = PH_IDLE;
                    st.wait_count = '0;
                end
            endcase
            r.scl_level = st.scl;
            r.sda_level = st.sda;
            r.sda_drive = st.drv;
            r.busy_res = (st.phase != PH_IDLE);
            expected_q.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            errors++;
            $display("%0t ns: %s", $time, msg);
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                flag_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(i2cm_out_t got);
            i2cm_out_t want;
            if (expected_q.size() == 0) begin
                flag_mismatch($sformatf("result 0x%0h arrived with no tick pending", got));
                return;
            end
            want = expected_q.pop_front();
            check_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
            check_field("sda_level", 8'(got.sda_level), 8'(want.sda_level));
            check_field("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
            check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            check_field("done_res", 8'(got.done_res), 8'(want.done_res));
            check_field("rx_byte", got.rx_byte, want.rx_byte);
            check_field("ack_failed", 8'(got.ack_failed), 8'(want.ack_failed));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    i2cm_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    i2cm_out_t            m_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [REG_W-1:0]     cfg_wr_data;

    // Percentage of cycles in which the sender holds back and the receiver stalls.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // High SDA samples the emulated slave gives before pulling SDA low for its ack.
    int unsigned ack_delay;
    // Fixed SDA level presented during reads, or SDA_FREE for random bits.
    int          sda_fixed;
    int unsigned idle_cycles = 0;

    line_scoreboard sb;

    i2c_master_bit_engine dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: every transfer is checked against the oldest pending tick, and
    // m_ready is redrawn each cycle so that stalls hit every phase of a command.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (m_valid && m_ready) sb.check_result(m_data);
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Hang detection: the run ends if neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // A tick while a command runs: mostly no request, sometimes a request the
    // engine has to ignore. During an ack poll the emulated slave answers after
    // ack_delay high samples; elsewhere SDA is random unless a read pins it.
    function automatic i2cm_in_t busy_tick();
        i2cm_in_t t;
        t.req_type = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : REQ_NONE;
        t.tx_byte = 8'($urandom);
        t.give_ack = 1'($urandom_range(1));
        case (sb.st.phase)
            PH_WA_SET, PH_WA_HIGH, PH_WA_POLL: begin
                t.sda_in = (ack_delay != 0);
                if (sb.st.phase == PH_WA_POLL && ack_delay != 0) ack_delay--;
            end
            default: begin
                t.sda_in = (sda_fixed == SDA_FREE) ? 1'($urandom_range(1)) : 1'(sda_fixed);
            end
        endcase
        return t;
    endfunction

    // A tick while the engine is idle: mostly a real command, with a little noise
    // from empty and undefined request codes. A wait for ack picks how long the
    // slave takes, and about a quarter of them never get an ack at all.
    function automatic i2cm_in_t command_tick();
        i2cm_in_t    t;
        int unsigned pick;
        pick = $urandom_range(99);
        t.tx_byte = 8'($urandom);
        t.give_ack = 1'($urandom_range(1));
        t.sda_in = 1'($urandom_range(1));
        if (pick < 4) begin
            t.req_type = REQ_NONE;
        end else if (pick < 7) begin
            t.req_type = REQ_RSVD_6;
        end else if (pick < 10) begin
            t.req_type = REQ_RSVD_7;
        end else if (pick < 25) begin
            t.req_type = REQ_START;
        end else if (pick < 40) begin
            t.req_type = REQ_STOP;
        end else if (pick < 62) begin
            t.req_type = REQ_WRITE;
        end else if (pick < 80) begin
            t.req_type = REQ_WAIT_ACK;
            ack_delay = ($urandom_range(3) == 0) ? NO_ACK : $urandom_range(6);
        end else begin
            t.req_type = REQ_READ;
        end
        return t;
    endfunction

    // Offers one tick and returns at the edge where it is transferred. The sender
    // may first drop valid for a random number of cycles; otherwise valid stays
    // high straight into the next tick.
    task automatic send_tick(i2cm_in_t t);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= t;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(t);
    endtask

    // Keeps the clock of ticks running until the predicted engine is idle again.
    task automatic finish_command();
        while (sb.st.phase != PH_IDLE) send_tick(busy_tick());
    endtask

    task automatic issue(logic [2:0] req, logic [7:0] tx, logic ack_bit, logic sda);
        i2cm_in_t t;
        t = '{req, tx, ack_bit, sda};
        send_tick(t);
        finish_command();
    endtask

    // Stops offering ticks and waits until every expected result has come back,
    // so the engine holds no tick in flight.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [REG_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // Register writes happen only with both channels empty.
    task automatic configure(logic [7:0] edge_hold, logic [7:0] half_bit,
                             logic [7:0] settle, logic [7:0] timeout);
        drain();
        write_reg(CFG_EDGE_HOLD, edge_hold);
        write_reg(CFG_HALF_BIT, half_bit);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_ACK_TIMEOUT, timeout);
    endtask

    // Random traffic for a fixed number of ticks, then the last command is run out.
    task automatic random_phase(int unsigned ticks);
        for (int unsigned n = 0; n < ticks; n++)
            send_tick((sb.st.phase == PH_IDLE) ? command_tick() : busy_tick());
        finish_command();
    endtask

    initial begin
        sb = new;
        sb.reset_state();
        send_idle_pct = 24;
        recv_idle_pct = 67;
        ack_delay = 0;
        sda_fixed = SDA_FREE;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_index <= '0;
        cfg_wr_data <= '0;
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset tick counts. A write offered in the middle of
        // a start condition must be ignored.
        send_tick('{REQ_START, 8'h3C, 1'b0, 1'b1});
        send_tick('{REQ_WRITE, 8'h3C, 1'b0, 1'b1});
        finish_command();
        issue(REQ_WRITE, 8'hFF, 1'b1, 1'b1);
        // The slave acks on the very first poll sample.
        ack_delay = 0;
        issue(REQ_WAIT_ACK, 8'h00, 1'b0, 1'b0);
        issue(REQ_STOP, 8'h00, 1'b0, 1'b1);

        // All registers at zero: every hold lasts one tick and the first high
        // sample of an ack poll already fails it, which forces a stop.
        configure(8'd0, 8'd0, 8'd0, 8'd0);
        issue(REQ_START, 8'h00, 1'b1, 1'b0);
        issue(REQ_WRITE, 8'h00, 1'b0, 1'b0);
        ack_delay = NO_ACK;
        issue(REQ_WAIT_ACK, 8'hFF, 1'b1, 1'b1);
        // Reads of an all-ones byte followed by an ack, and of an all-zeros byte
        // followed by a nack.
        sda_fixed = 1;
        issue(REQ_READ, 8'h00, 1'b1, 1'b1);
        sda_fixed = 0;
        issue(REQ_READ, 8'hFF, 1'b0, 1'b0);
        sda_fixed = SDA_FREE;
        // Undefined codes and an empty request must leave the engine idle.
        issue(REQ_RSVD_6, 8'hAA, 1'b1, 1'b0);
        issue(REQ_RSVD_7, 8'h55, 1'b0, 1'b1);
        issue(REQ_NONE, 8'hFF, 1'b1, 1'b1);
        issue(REQ_STOP, 8'hFF, 1'b1, 1'b0);

        // Largest timeout: an ack that never comes is polled for the full count.
        configure(8'd1, 8'd1, 8'd1, 8'd255);
        ack_delay = NO_ACK;
        issue(REQ_WAIT_ACK, 8'h00, 1'b0, 1'b1);

        // Random part in three idling modes: sender light and receiver heavy, then
        // the reverse, then both at full rate. Each mode runs through several small
        // settings, and the first mode starts with every register at one.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 67 : 0;
            recv_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 24 : 0;
            for (int p = 0; p < 4; p++) begin
                if (mode == 0 && p == 0) begin
                    configure(8'd1, 8'd1, 8'd1, 8'd1);
                end else begin
                    configure(8'($urandom_range(4, 1)), 8'($urandom_range(3, 1)),
                              8'($urandom_range(3, 1)), 8'($urandom_range(12, 1)));
                end
                random_phase(TICKS_PER_PHASE);
            end
        end

        // Let the last results come home, then watch a few more cycles for
        // anything the engine should not have sent.
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.expected_q.size() != 0) sb.flag_mismatch("results still pending at the end");
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
src/i2cm_pkg.sv
src/i2cm_cfg.sv
src/i2cm_step.sv
src/i2cm_out_reg.sv
src/i2c_master_bit_engine.sv
tb/tb.sv
